### src/hsv2rgb_pkg.sv
// Package with the pixel types, hue sector codes and divide-by-255 helpers.
package hsv2rgb_pkg;

    localparam logic [7:0]  CH_MAX = 8'd255;
    localparam logic [15:0] CH_SQ  = 16'd65025;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
        logic [7:0] alpha_in;
    } t_hsv_pixel;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha_out;
    } t_rgb_pixel;

    // Sixty-degree hue sectors, red through magenta.
    typedef enum logic [2:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } t_sector;

    // floor(y / 255) for y up to 65025; exact over that range.
    function automatic logic [7:0] div255_16(input logic [15:0] y);
        logic [16:0] acc;
        acc = {1'b0, y} + {9'd0, y[15:8]} + 17'd1;
        return acc[15:8];
    endfunction

    // floor(z / 255) for z up to 255*65025. The estimate z*257/65536 is at
    // most one below the true quotient, so one correction step is enough.
    function automatic logic [15:0] div255_24(input logic [23:0] z);
        logic [32:0] prod;
        logic [15:0] est;
        logic [24:0] rmd;
        prod = {1'b0, z, 8'd0} + {9'd0, z};
        est  = prod[31:16];
        rmd  = {1'b0, z} - ({1'b0, est, 8'd0} - {9'd0, est});
        return (rmd >= 25'd255) ? est + 16'd1 : est;
    endfunction

endpackage

### src/hsv_to_rgb_8bit_core.sv
// HSV to RGB pixel converter, five-stage pipeline with per-stage flow control.
//
// Converts one 8-bit HSV pixel plus alpha into 8-bit RGB plus alpha every
// clock when not stalled. Hue 0..255 covers the full circle, with 255
// wrapping back to red. A word enters the first of five register stages at
// the edge that accepts it and moves through them in order. The stages are
// hue sector and remainder, three 8x8 products, two 8x16 products with the
// p channel divide, a first divide by 255, then a second divide by 255 and
// the channel mux, which feeds the output register. Every stage has its own
// valid bit and loads whenever the stage after it can move, so bubbles are
// squeezed out during a stall and a new word is taken on every cycle that
// the output side keeps up. The block holds no other state.
module hsv_to_rgb_8bit_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  hsv2rgb_pkg::t_hsv_pixel i_pixel,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output hsv2rgb_pkg::t_rgb_pixel o_pixel
);
    import hsv2rgb_pkg::*;

    // Stage 1: sector and remainder.
    logic        r_s1_vld;
    t_sector     r_s1_sec;
    logic [7:0]  r_s1_rem;
    logic [7:0]  r_s1_sat;
    logic [7:0]  r_s1_val;
    logic [7:0]  r_s1_alpha;
    // Stage 2: 8x8 products.
    logic        r_s2_vld;
    t_sector     r_s2_sec;
    logic [15:0] r_s2_sr;
    logic [15:0] r_s2_st;
    logic [15:0] r_s2_vp;
    logic [7:0]  r_s2_val;
    logic [7:0]  r_s2_alpha;
    // Stage 3: full-scale products.
    logic        r_s3_vld;
    t_sector     r_s3_sec;
    logic [23:0] r_s3_zq;
    logic [23:0] r_s3_zt;
    logic [7:0]  r_s3_p;
    logic [7:0]  r_s3_val;
    logic [7:0]  r_s3_alpha;
    // Stage 4: first divide by 255.
    logic        r_s4_vld;
    t_sector     r_s4_sec;
    logic [15:0] r_s4_q1;
    logic [15:0] r_s4_t1;
    logic [7:0]  r_s4_p;
    logic [7:0]  r_s4_val;
    logic [7:0]  r_s4_alpha;
    // Stage 5: output register.
    logic        r_s5_vld;
    t_rgb_pixel  r_s5_pix;

    logic en1, en2, en3, en4, en5;

    logic [10:0] n_x;
    t_sector     n_sec;
    logic [10:0] n_base;
    logic [7:0]  n_rem;
    logic [15:0] n_nq;
    logic [15:0] n_nt;
    logic [7:0]  n_q;
    logic [7:0]  n_t;
    t_rgb_pixel  n_pix;

    // Ready ripples back: a stage may load when empty or when it drains.
    assign en5 = !r_s5_vld || i_out_ready;
    assign en4 = !r_s4_vld || en5;
    assign en3 = !r_s3_vld || en4;
    assign en2 = !r_s2_vld || en3;
    assign en1 = !r_s1_vld || en2;

    assign o_in_ready  = en1;
    assign o_out_valid = r_s5_vld;
    assign o_pixel     = r_s5_pix;

    // x = 6*H, then sector = x / 255 by compare against the sector edges.
    // A full-circle hue lands on 1530 and wraps to red with no remainder.
    always_comb begin
        n_x = {1'b0, i_pixel.hue, 2'b00} + {2'b00, i_pixel.hue, 1'b0};
        if (n_x >= 11'd1530) begin
            n_sec  = SEC_RED;
            n_base = n_x;
        end else if (n_x >= 11'd1275) begin
            n_sec  = SEC_MAGENTA;
            n_base = 11'd1275;
        end else if (n_x >= 11'd1020) begin
            n_sec  = SEC_BLUE;
            n_base = 11'd1020;
        end else if (n_x >= 11'd765) begin
            n_sec  = SEC_CYAN;
            n_base = 11'd765;
        end else if (n_x >= 11'd510) begin
            n_sec  = SEC_GREEN;
            n_base = 11'd510;
        end else if (n_x >= 11'd255) begin
            n_sec  = SEC_YELLOW;
            n_base = 11'd255;
        end else begin
            n_sec  = SEC_RED;
            n_base = 11'd0;
        end
        n_rem = 8'(n_x - n_base);
    end

    assign n_nq = CH_SQ - r_s2_sr;
    assign n_nt = CH_SQ - r_s2_st;
    assign n_q  = div255_16(r_s4_q1);
    assign n_t  = div255_16(r_s4_t1);

    always_comb begin
        n_pix.alpha_out = r_s4_alpha;
        case (r_s4_sec)
            SEC_RED: begin
                n_pix.red = r_s4_val; n_pix.green = n_t;      n_pix.blue = r_s4_p;
            end
            SEC_YELLOW: begin
                n_pix.red = n_q;      n_pix.green = r_s4_val; n_pix.blue = r_s4_p;
            end
            SEC_GREEN: begin
                n_pix.red = r_s4_p;   n_pix.green = r_s4_val; n_pix.blue = n_t;
            end
            SEC_CYAN: begin
                n_pix.red = r_s4_p;   n_pix.green = n_q;      n_pix.blue = r_s4_val;
            end
            SEC_BLUE: begin
                n_pix.red = n_t;      n_pix.green = r_s4_p;   n_pix.blue = r_s4_val;
            end
            default: begin
                n_pix.red = r_s4_val; n_pix.green = r_s4_p;   n_pix.blue = n_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else begin
            if (en1) begin
                r_s1_vld <= i_in_valid;
            end
            if (en2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (en3) begin
                r_s3_vld <= r_s2_vld;
            end
            if (en4) begin
                r_s4_vld <= r_s3_vld;
            end
            if (en5) begin
                r_s5_vld <= r_s4_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_sec   <= n_sec;
            r_s1_rem   <= n_rem;
            r_s1_sat   <= i_pixel.saturation;
            r_s1_val   <= i_pixel.brightness;
            r_s1_alpha <= i_pixel.alpha_in;
        end
        if (en2) begin
            r_s2_sec   <= r_s1_sec;
            r_s2_sr    <= 16'(r_s1_sat) * 16'(r_s1_rem);
            r_s2_st    <= 16'(r_s1_sat) * 16'(CH_MAX - r_s1_rem);
            r_s2_vp    <= 16'(r_s1_val) * 16'(CH_MAX - r_s1_sat);
            r_s2_val   <= r_s1_val;
            r_s2_alpha <= r_s1_alpha;
        end
        if (en3) begin
            r_s3_sec   <= r_s2_sec;
            r_s3_zq    <= 24'(r_s2_val) * 24'(n_nq);
            r_s3_zt    <= 24'(r_s2_val) * 24'(n_nt);
            r_s3_p     <= div255_16(r_s2_vp);
            r_s3_val   <= r_s2_val;
            r_s3_alpha <= r_s2_alpha;
        end
        if (en4) begin
            r_s4_sec   <= r_s3_sec;
            r_s4_q1    <= div255_24(r_s3_zq);
            r_s4_t1    <= div255_24(r_s3_zt);
            r_s4_p     <= r_s3_p;
            r_s4_val   <= r_s3_val;
            r_s4_alpha <= r_s3_alpha;
        end
        if (en5) begin
            r_s5_pix <= n_pix;
        end
    end

endmodule

### src/hsv2rgb_checker.sv
// Port-level checker for the HSV to RGB converter and its bind.
module hsv2rgb_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input hsv2rgb_pkg::t_hsv_pixel i_pixel,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input hsv2rgb_pkg::t_rgb_pixel o_pixel
);
    import hsv2rgb_pkg::*;

    // The pipeline comes out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    // A word waiting at the output stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel))
        else $error("stalled output word changed or vanished");

    // Input back-pressure only comes from a blocked, full output stage.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input not ready although output can drain");

    // Once the output is free, the input side must be open.
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready with an empty output stage");

endmodule

bind hsv_to_rgb_8bit_core hsv2rgb_checker u_hsv2rgb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_pixel     (i_pixel),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_pixel     (o_pixel)
);
